FILE: hdl/qslnf_pkg.sv
// shared types and constants for the quad surface load nodal force block
// no dependencies

package qslnf_pkg;

    localparam int COORD_W  = 24;
    localparam int LOAD_W   = 16;
    localparam int FORCE_W  = 64;
    localparam int SUM_W    = 26;
    localparam int PROD_W   = 52;
    localparam int TERM_W   = 53;
    localparam int S_W      = 56;
    localparam int N_LANES  = 3;

    localparam logic [1:0] FIRST_NODE = 2'd0;
    localparam logic [1:0] LAST_NODE  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] node1_x;
        logic signed [COORD_W-1:0] node1_y;
        logic signed [COORD_W-1:0] node2_x;
        logic signed [COORD_W-1:0] node2_y;
        logic signed [COORD_W-1:0] node3_x;
        logic signed [COORD_W-1:0] node3_y;
        logic signed [COORD_W-1:0] node4_x;
        logic signed [COORD_W-1:0] node4_y;
        logic signed [LOAD_W-1:0]  pressure_x;
        logic signed [LOAD_W-1:0]  pressure_y;
        logic signed [LOAD_W-1:0]  pressure_z;
    } load_item_t;

    typedef struct packed {
        logic [1:0]                node_index;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      last_node;
    } force_item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] idx;
    } node_ctl_t;

    typedef logic [N_LANES-1:0][LOAD_W-1:0] load_vec_t;

    // residue mod 3 of a small sum
    function automatic logic [1:0] mod3_small(input logic [3:0] v);
        logic [1:0] r;
        case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
            default:                              r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/qslnf_front.sv
// jacobian coefficient stages and the node sequencer
// depends on qslnf_pkg

module qslnf_front
    import qslnf_pkg::*;
#(
    parameter int GAUSS_POINTS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_stall,
    input  load_item_t            load,
    input  logic                  adv,
    output node_ctl_t             ctl,
    output logic signed [S_W-1:0] s_sum,
    output load_vec_t             pres
);

    logic signed [SUM_W-1:0] x0, x1, x2, x3, y0, y1, y2, y3;
    logic signed [SUM_W-1:0] ca, cb, cc, cd, ce, cf;

    logic                     s1_v_reg, s1_v_next;
    logic signed [PROD_W-1:0] p_af_reg, p_dc_reg, p_ae_reg, p_db_reg, p_bf_reg, p_ec_reg;
    load_vec_t                s1_q_reg;

    logic                     s2_v_reg, s2_v_next;
    logic signed [TERM_W-1:0] s2_t0_reg, s2_t1_reg, s2_t2_reg;
    load_vec_t                s2_q_reg;

    logic                     sq_v_reg, sq_v_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic signed [TERM_W-1:0] t0_reg, t1_reg, t2_reg;
    load_vec_t                q_reg;

    node_ctl_t                ctl_reg, ctl_next;
    logic signed [S_W-1:0]    s_sum_reg, s_sum_next;
    load_vec_t                pres_reg;

    logic accept, seq_load, st2_free, s1_move;
    logic signed [S_W-1:0] base;

    assign x0 = SUM_W'(load.node1_x);
    assign x1 = SUM_W'(load.node2_x);
    assign x2 = SUM_W'(load.node3_x);
    assign x3 = SUM_W'(load.node4_x);
    assign y0 = SUM_W'(load.node1_y);
    assign y1 = SUM_W'(load.node2_y);
    assign y2 = SUM_W'(load.node3_y);
    assign y3 = SUM_W'(load.node4_y);

    assign ca = -x0 + x1 + x2 - x3;
    assign cb =  x0 - x1 + x2 - x3;
    assign cc = -x0 - x1 + x2 + x3;
    assign cd = -y0 + y1 + y2 - y3;
    assign ce =  y0 - y1 + y2 - y3;
    assign cf = -y0 - y1 + y2 + y3;

    assign seq_load   = adv && s2_v_reg && (!sq_v_reg || cnt_reg == LAST_NODE);
    assign st2_free   = !s2_v_reg || seq_load;
    assign s1_move    = s1_v_reg && st2_free;
    assign load_stall = s1_v_reg && !st2_free;
    assign accept     = load_valid && !load_stall;

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (accept)
        begin
            s1_v_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_v_next = 1'b0;
        end

        s2_v_next = s2_v_reg;
        if (s1_move)
        begin
            s2_v_next = 1'b1;
        end
        else if (seq_load)
        begin
            s2_v_next = 1'b0;
        end

        sq_v_next = sq_v_reg;
        cnt_next  = cnt_reg;
        if (seq_load)
        begin
            sq_v_next = 1'b1;
            cnt_next  = FIRST_NODE;
        end
        else if (adv && sq_v_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == LAST_NODE)
            begin
                sq_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
            cnt_reg  <= FIRST_NODE;
            ctl_reg  <= '0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            sq_v_reg <= sq_v_next;
            cnt_reg  <= cnt_next;
            if (adv)
            begin
                ctl_reg <= ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_af_reg <= ca * cf;
            p_dc_reg <= cd * cc;
            p_ae_reg <= ca * ce;
            p_db_reg <= cd * cb;
            p_bf_reg <= cb * cf;
            p_ec_reg <= ce * cc;
            s1_q_reg <= {load.pressure_z, load.pressure_y, load.pressure_x};
        end
        if (s1_move)
        begin
            s2_t0_reg <= TERM_W'(p_af_reg) - TERM_W'(p_dc_reg);
            s2_t1_reg <= TERM_W'(p_ae_reg) - TERM_W'(p_db_reg);
            s2_t2_reg <= TERM_W'(p_bf_reg) - TERM_W'(p_ec_reg);
            s2_q_reg  <= s1_q_reg;
        end
        if (seq_load)
        begin
            t0_reg <= s2_t0_reg;
            t1_reg <= s2_t1_reg;
            t2_reg <= s2_t2_reg;
            q_reg  <= s2_q_reg;
        end
        if (adv)
        begin
            s_sum_reg <= s_sum_next;
            pres_reg  <= q_reg;
        end
    end

    // corners 1 and 4 sit at xi = -1, corners 1 and 2 at eta = -1
    always_comb
    begin
        base       = S_W'(t0_reg) + S_W'(t0_reg) + S_W'(t0_reg);
        s_sum_next = base;
        if (GAUSS_POINTS >= 2)
        begin
            case (cnt_reg)
                2'd0:    s_sum_next = base - S_W'(t1_reg) - S_W'(t2_reg);
                2'd1:    s_sum_next = base + S_W'(t1_reg) - S_W'(t2_reg);
                2'd2:    s_sum_next = base + S_W'(t1_reg) + S_W'(t2_reg);
                default: s_sum_next = base - S_W'(t1_reg) + S_W'(t2_reg);
            endcase
        end
    end

    assign ctl_next.valid = sq_v_reg;
    assign ctl_next.idx   = cnt_reg;

    // weighted area is registered before the lanes take its magnitude
    assign ctl   = ctl_reg;
    assign s_sum = s_sum_reg;
    assign pres  = pres_reg;

endmodule

FILE: hdl/qslnf_lane.sv
// one force component lane: load times weighted area, divide by 48 rounded, saturate
// depends on qslnf_pkg

module qslnf_lane
    import qslnf_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [S_W-1:0]     s_sum,
    input  logic signed [LOAD_W-1:0]  q,
    output logic signed [FORCE_W-1:0] force_out
);

    localparam int NDIG = 5;
    localparam logic [15:0] RECIP3 = 16'd43691;
    localparam logic [15:0] THIRD  = 16'd21845;

    logic [S_W-1:0]    ms;
    logic [LOAD_W-1:0] mq;

    logic        neg1_reg, neg2_reg, neg3_reg;
    logic [43:0] pp_lo_reg;
    logic [42:0] pp_hi_reg;
    logic [71:0] m_sum;
    logic [67:0] n_reg;
    logic [79:0] dig;
    logic [NDIG-1:0][14:0] qd_reg, qd_next;
    logic [NDIG-1:0][1:0]  rd_reg, rd_next;
    logic [31:0] prod [NDIG];
    logic [79:0] quo;
    logic [3:0]  acc;
    logic [1:0]  r;

    assign ms = s_sum[S_W-1] ? S_W'(-s_sum) : S_W'(s_sum);
    assign mq = q[LOAD_W-1] ? LOAD_W'(-q) : LOAD_W'(q);

    assign m_sum = (72'(pp_hi_reg) << 28) + 72'(pp_lo_reg) + 72'd24;
    assign dig   = {12'd0, n_reg};

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            prod[i]    = 32'(dig[16*i +: 16]) * 32'(RECIP3);
            qd_next[i] = prod[i][31:17];
            rd_next[i] = 2'(dig[16*i +: 16] - 16'(qd_next[i]) * 16'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= s_sum[S_W-1] ^ q[LOAD_W-1];
            pp_lo_reg <= 44'(mq) * 44'(ms[27:0]);
            pp_hi_reg <= 43'(mq) * 43'(ms[54:28]);
            neg2_reg  <= neg1_reg;
            n_reg     <= m_sum[71:4];
            neg3_reg  <= neg2_reg;
            qd_reg    <= qd_next;
            rd_reg    <= rd_next;
        end
    end

    // carry into each digit is the residue of all digits above it
    always_comb
    begin
        acc = 4'd0;
        quo = '0;
        for (int i = NDIG - 1; i >= 0; i--)
        begin
            r = mod3_small(acc);
            quo[16*i +: 16] = 16'(16'(r) * THIRD) + 16'(qd_reg[i])
                            + 16'((3'(r) + 3'(rd_reg[i])) >= 3'd3);
            acc = acc + 4'(rd_reg[i]);
        end
    end

    always_comb
    begin
        if (neg3_reg)
        begin
            if (|quo[79:63])
            begin
                force_out = {1'b1, {(FORCE_W-1){1'b0}}};
            end
            else
            begin
                force_out = -$signed(quo[63:0]);
            end
        end
        else
        begin
            if (|quo[79:63])
            begin
                force_out = {1'b0, {(FORCE_W-1){1'b1}}};
            end
            else
            begin
                force_out = $signed(quo[63:0]);
            end
        end
    end

endmodule

FILE: hdl/quad_surface_load_nodal_forces.sv
// uniform load on a bilinear quad: four consistent nodal forces per item
// the first node result passes the front stages, lane and output registers; the
// rest follow in corner order. New items enter while older ones are in flight,
// and the sequencer feeds the shared x/y/z lanes one corner per unstalled cycle
// reset clears only valid bits and the node counter; no clearing pass
// depends on qslnf_pkg, qslnf_front, qslnf_lane

module quad_surface_load_nodal_forces
    import qslnf_pkg::*;
#(
    parameter int GAUSS_POINTS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    output logic        load_stall,
    input  load_item_t  load,
    output logic        force_valid,
    input  logic        force_stall,
    output force_item_t result
);

    // whole back end moves together unless a finished item is held
    logic adv;

    node_ctl_t             seq_ctl;
    logic signed [S_W-1:0] s_sum;
    load_vec_t             pres;

    // control travels beside the three lane registers
    node_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;

    logic signed [FORCE_W-1:0] lane_force [N_LANES];

    logic        force_valid_reg;
    force_item_t force_reg, force_next;

    assign adv = !(force_valid_reg && force_stall);

    qslnf_front #(
        .GAUSS_POINTS(GAUSS_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_stall (load_stall),
        .load       (load),
        .adv        (adv),
        .ctl        (seq_ctl),
        .s_sum      (s_sum),
        .pres       (pres)
    );

    // one lane per load component, all fed the same weighted area
    for (genvar c = 0; c < N_LANES; c++)
    begin : g_lane
        qslnf_lane u_lane (
            .clk       (clk),
            .en        (adv),
            .s_sum     (s_sum),
            .q         ($signed(pres[c])),
            .force_out (lane_force[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg        <= '0;
            ctl2_reg        <= '0;
            ctl3_reg        <= '0;
            force_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl1_reg        <= seq_ctl;
            ctl2_reg        <= ctl1_reg;
            ctl3_reg        <= ctl2_reg;
            force_valid_reg <= ctl3_reg.valid;
        end
    end

    // merge stage: the three lane results and the node tag form one item
    always_comb
    begin
        force_next.node_index = ctl3_reg.idx;
        force_next.force_x    = lane_force[0];
        force_next.force_y    = lane_force[1];
        force_next.force_z    = lane_force[2];
        force_next.last_node  = (ctl3_reg.idx == LAST_NODE);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            force_reg <= force_next;
        end
    end

    assign force_valid = force_valid_reg;
    assign result      = force_reg;

endmodule

FILE: verif/tb_quad_surface_load_nodal_forces.sv
// self-checking testbench for quad_surface_load_nodal_forces
// drives random and directed quad elements, checks the four nodal forces per item
// depends on qslnf_pkg and the quad_surface_load_nodal_forces rtl

module tb_quad_surface_load_nodal_forces;
    import qslnf_pkg::*;

    localparam int GP = 3;

    logic        clk;
    logic        rst_n;
    logic        load_valid;
    logic        load_stall;
    load_item_t  load;
    logic        force_valid;
    logic        force_stall;
    force_item_t result;

    // elements waiting to be driven, and node forces waiting to come back
    load_item_t  element_queue[$];
    force_item_t nodal_force_queue[$];
    int          error_count = 0;
    bit          stimulus_done = 1'b0;
    bit          load_taken;

    quad_surface_load_nodal_forces #(.GAUSS_POINTS(GP)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (load_valid),
        .load_stall  (load_stall),
        .load        (load),
        .force_valid (force_valid),
        .force_stall (force_stall),
        .result      (result)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // q * s / 48, rounded half away from zero, saturated to 64 bits
    function automatic logic signed [63:0] load_share(input longint q, input logic signed [127:0] s);
        logic signed [127:0] prod;
        logic signed [127:0] mag;
        logic signed [127:0] res;
        prod = q * s;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 24) / 48;
        res  = (prod < 0) ? -mag : mag;
        if (res > 128'sh7FFFFFFFFFFFFFFF)
            return 64'sh7FFFFFFFFFFFFFFF;
        if (res < -128'sh8000000000000000)
            return 64'sh8000000000000000;
        return res[63:0];
    endfunction

    // append an element to the stimulus queue
    function automatic void add_element(input load_item_t it);
        element_queue.insert(element_queue.size(), it);
    endfunction

    // the four consistent nodal forces of one element, in corner order
    task automatic predict_nodal_forces(input load_item_t it);
        longint x0, x1, x2, x3, y0, y1, y2, y3;
        longint ca, cb, cc, cd, ce, cf;
        logic signed [127:0] t0, t1, t2, s;
        longint xi, eta;
        force_item_t f;
        x0 = it.node1_x; x1 = it.node2_x; x2 = it.node3_x; x3 = it.node4_x;
        y0 = it.node1_y; y1 = it.node2_y; y2 = it.node3_y; y3 = it.node4_y;
        ca = -x0 + x1 + x2 - x3;
        cb = x0 - x1 + x2 - x3;
        cc = -x0 - x1 + x2 + x3;
        cd = -y0 + y1 + y2 - y3;
        ce = y0 - y1 + y2 - y3;
        cf = -y0 - y1 + y2 + y3;
        t0 = ca * cf - cd * cc;
        t1 = ca * ce - cd * cb;
        t2 = cb * cf - ce * cc;
        for (int k = 0; k < 4; k++)
        begin
            // natural coordinates of corner k
            xi  = (k == 1 || k == 2) ? 1 : -1;
            eta = (k >= 2) ? 1 : -1;
            s = 3 * t0;
            if (GP >= 2)
                s = s + xi * t1 + eta * t2;
            f.node_index = k[1:0];
            f.force_x    = load_share(longint'(it.pressure_x), s);
            f.force_y    = load_share(longint'(it.pressure_y), s);
            f.force_z    = load_share(longint'(it.pressure_z), s);
            f.last_node  = (k[1:0] == LAST_NODE);
            nodal_force_queue.insert(nodal_force_queue.size(), f);
        end
    endtask

    function automatic load_item_t random_element();
        load_item_t it;
        int mode;
        logic [255:0] rbits;
        mode  = $urandom_range(0, 3);
        rbits = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        it    = rbits[$bits(load_item_t)-1:0];
        if (mode == 0)
        begin
            // small well-formed quad around a random origin
            logic signed [23:0] ox, oy;
            ox = 24'($urandom); oy = 24'($urandom);
            ox = ox >>> 4; oy = oy >>> 4;
            it.node1_x = ox;
            it.node1_y = oy;
            it.node2_x = ox + 24'($urandom_range(1, 4000));
            it.node2_y = oy + 24'($urandom_range(0, 300));
            it.node3_x = it.node2_x + 24'($urandom_range(0, 300));
            it.node3_y = oy + 24'($urandom_range(1, 4000));
            it.node4_x = ox - 24'($urandom_range(0, 300));
            it.node4_y = it.node3_y;
        end
        return it;
    endfunction

    function automatic load_item_t make_quad(input int x1, y1, x2, y2, x3, y3, x4, y4,
                                             input int qx, qy, qz);
        load_item_t it;
        it.node1_x = 24'(x1); it.node1_y = 24'(y1);
        it.node2_x = 24'(x2); it.node2_y = 24'(y2);
        it.node3_x = 24'(x3); it.node3_y = 24'(y3);
        it.node4_x = 24'(x4); it.node4_y = 24'(y4);
        it.pressure_x = 16'(qx); it.pressure_y = 16'(qy); it.pressure_z = 16'(qz);
        return it;
    endfunction

    // stimulus: directed corners of the input space, then random elements
    initial
    begin
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        // unit square, counterclockwise
        add_element(make_quad(0, 0, 256, 0, 256, 256, 0, 256, 1, -1, 7));
        // clockwise order flips the sign of the forces
        add_element(make_quad(0, 0, 0, 256, 256, 256, 256, 0, 100, 200, -300));
        // degenerate quads: collapsed edge and zero area
        add_element(make_quad(0, 0, 512, 0, 512, 0, 0, 256, 5, 5, 5));
        add_element(make_quad(10, 10, 10, 10, 10, 10, 10, 10, 32767, -32768, 1));
        add_element(make_quad(0, 0, 100, 100, 200, 200, 300, 300, 9, 9, 9));
        // zero load
        add_element(make_quad(0, 0, 300, 10, 310, 290, -5, 280, 0, 0, 0));
        // largest coordinates and loads, both signs
        add_element(make_quad(mn, mn, mx, mn, mx, mx, mn, mx, 32767, -32768, -1));
        add_element(make_quad(mn, mn, mx, mn, mx, mx, mn, mx, -32768, -32768, 32767));
        add_element(make_quad(mx, mx, mn, mx, mn, mn, mx, mn, 32767, 32767, -32768));
        add_element(make_quad(mn, 0, mx, mn, 0, mx, mn, mx, -32768, 1, 32767));
        add_element(make_quad(mx, mx, mx, mx, mx, mx, mx, mx, -1, -1, -1));
        add_element(make_quad(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        // distorted, nonconvex quad
        add_element(make_quad(0, 0, 1000, 0, 100, 100, 0, 1000, 321, -123, 4));
        add_element(make_quad(mn, mx, mx, mn, mn, mn, mx, mx, 32767, 32767, 32767));
        repeat (450)
            add_element(random_element());
    end

    // an item counts as taken only at the rising edge that accepted it
    always @(posedge clk)
        load_taken <= load_valid && !load_stall;

    // driver: bursts of items with random gaps, changes at the falling edge
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_valid <= 1'b0;
            load       <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!load_valid || load_taken)
        begin
            // previous item accepted (or none pending), choose what comes next
            if (gap_left > 0)
            begin
                load_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (element_queue.size() > 0)
            begin
                load       <= element_queue.pop_front();
                load_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                load_valid    <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    // receiver stall pattern: runs of stall and no stall of random length
    int stall_run;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_stall <= 1'b0;
            stall_run   <= 0;
        end
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            force_stall <= ($urandom_range(0, 2) == 0);
            stall_run   <= $urandom_range(0, 15);
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        force_item_t exp_f;
        if (rst_n)
        begin
            if (load_valid && !load_stall)
                predict_nodal_forces(load);
            if (force_valid && !force_stall)
            begin
                if (nodal_force_queue.size() == 0)
                begin
                    $error("unexpected node result, node_index %0d", result.node_index);
                    error_count++;
                end
                else
                begin
                    exp_f = nodal_force_queue.pop_front();
                    if (result.node_index !== exp_f.node_index)
                    begin
                        $error("node_index expected %0d got %0d", exp_f.node_index,
                               result.node_index);
                        error_count++;
                    end
                    if (result.force_x !== exp_f.force_x)
                    begin
                        $error("force_x expected %0d got %0d", exp_f.force_x, result.force_x);
                        error_count++;
                    end
                    if (result.force_y !== exp_f.force_y)
                    begin
                        $error("force_y expected %0d got %0d", exp_f.force_y, result.force_y);
                        error_count++;
                    end
                    if (result.force_z !== exp_f.force_z)
                    begin
                        $error("force_z expected %0d got %0d", exp_f.force_z, result.force_z);
                        error_count++;
                    end
                    if (result.last_node !== exp_f.last_node)
                    begin
                        $error("last_node expected %0d got %0d", exp_f.last_node,
                               result.last_node);
                        error_count++;
                    end
                end
            end
        end
    end

    // reset, then wait for the stimulus to drain and the results to arrive
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stimulus_done);
        wait (nodal_force_queue.size() == 0);
        // run on to catch any extra results
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // timeout: ~470 items, 4 results each, long stalls and gaps all the way,
    // with a wide margin on top
    initial
    begin
        #10000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: quad_surface_load_nodal_forces.f
hdl/qslnf_pkg.sv
hdl/qslnf_front.sv
hdl/qslnf_lane.sv
hdl/quad_surface_load_nodal_forces.sv
verif/tb_quad_surface_load_nodal_forces.sv
